@@ hdl/spr_pkg.sv @@
// Shared types and codes for the source position run table.
// No dependencies; used by spr_search, the top level and the bench.
package spr_pkg;

  typedef enum logic [1:0] {
    OP_TRACKED   = 2'd0,
    OP_UNTRACKED = 2'd1,
    OP_LOOKUP    = 2'd2,
    OP_NONE      = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK           = 2'd0,
    ST_EMPTY        = 2'd1,
    ST_TABLE_FULL   = 2'd2,
    ST_COUNTER_FULL = 2'd3
  } st_t;

  typedef enum logic [1:0] {
    SR_IDLE,
    SR_STEP,
    SR_FETCH
  } srch_state_t;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [15:0] src_row;
    logic [15:0] src_col;
    logic [2:0]  extra_bytes;
    logic [15:0] query_offset;
  } in_word_t;

  typedef struct packed {
    logic [15:0] found_row;
    logic [15:0] found_col;
    logic [15:0] found_offset;
    logic [16:0] byte_total;
    logic [1:0]  status;
  } out_word_t;

  // search engine status seen by the top level
  typedef struct packed {
    logic busy;
    logic done;
  } srch_stat_t;

endpackage

@@ hdl/spr_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module spr_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ hdl/spr_search.sv @@
// Binary search engine: walks the run table through the RAM read port.
// Depends on spr_pkg; the RAM itself lives in the top level.
module spr_search #(
  parameter int TABLE_DEPTH = 256,
  parameter int CNT_W       = 17
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  input  logic [$clog2(TABLE_DEPTH+1)-1:0] count,
  input  logic [15:0]                      query,
  output logic [$clog2(TABLE_DEPTH)-1:0]   rd_addr,
  input  logic [CNT_W-1:0]                 rd_offset,
  output spr_pkg::srch_stat_t              stat
);
  import spr_pkg::*;

  localparam int RC_W  = $clog2(TABLE_DEPTH + 1);
  localparam int IDX_W = $clog2(TABLE_DEPTH);
  localparam int CMP_W = CNT_W + 16;

  srch_state_t      state, state_next;
  logic [RC_W-1:0]  lo, lo_next, hi, hi_next, mid, mid_next;
  logic [15:0]      qry;
  logic [RC_W-1:0]  lo_n, hi_n;
  logic             gt;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= SR_IDLE;
    end else begin
      state <= state_next;
    end
    lo  <= lo_next;
    hi  <= hi_next;
    mid <= mid_next;
    if (state == SR_IDLE && start) begin
      qry <= query;
    end
  end

  always_comb begin
    state_next = state;
    lo_next    = lo;
    hi_next    = hi;
    mid_next   = mid;
    rd_addr    = mid[IDX_W-1:0];
    stat       = '0;
    gt         = CMP_W'(rd_offset) > CMP_W'(qry);
    lo_n       = gt ? lo : mid + RC_W'(1);
    hi_n       = gt ? mid : hi;
    unique case (state)
      SR_IDLE: begin
        if (start) begin
          lo_next    = '0;
          hi_next    = count;
          mid_next   = count >> 1;
          rd_addr    = mid_next[IDX_W-1:0];
          state_next = SR_STEP;
        end
      end
      SR_STEP: begin
        // rd_offset belongs to entry mid
        stat.busy = 1'b1;
        lo_next   = lo_n;
        hi_next   = hi_n;
        if (lo_n < hi_n) begin
          mid_next = lo_n + ((hi_n - lo_n) >> 1);
          rd_addr  = mid_next[IDX_W-1:0];
        end else begin
          // last entry not above the query, entry 0 when none
          mid_next   = (lo_n == '0) ? '0 : lo_n - RC_W'(1);
          rd_addr    = mid_next[IDX_W-1:0];
          state_next = SR_FETCH;
        end
      end
      SR_FETCH: begin
        stat.busy  = 1'b1;
        stat.done  = 1'b1;
        state_next = SR_IDLE;
      end
      default: begin
        state_next = SR_IDLE;
      end
    endcase
  end

endmodule

@@ hdl/source_position_run_table.sv @@
// Source position run table: byte counter plus a run-length table that maps
// byte offsets to source row and column.
// Command channel: cmd is taken at a clock edge with start high and busy low.
//   opcode tracked append adds one byte and a table entry when the position
//   changes; untracked append adds extra_bytes; lookup returns the last entry
//   whose offset is not above query_offset (entry 0 if all lie above).
// Result channel: one word per command on result, valid for the single cycle
//   that done is high; there is no backpressure, the receiver must take it.
// Timing: appends, unused opcodes and lookups on an empty table give done
//   in the cycle after acceptance with busy never raised, so a command may be
//   issued every cycle. A lookup raises busy while it searches the table with
//   one table RAM read per search step; busy stays high until the result is
//   registered.
// Reset (rst, synchronous): clears the byte counter, the entry count and the
//   control state; table contents stay undefined and are never read unwritten.
// Depends on spr_pkg, spr_ram and spr_search.
module source_position_run_table #(
  parameter int TABLE_DEPTH = 256,
  parameter int CODE_LIMIT  = 65536
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  spr_pkg::in_word_t  cmd,
  output logic               done,
  output spr_pkg::out_word_t result
);
  import spr_pkg::*;

  localparam int CNT_W = $clog2(CODE_LIMIT + 1);
  localparam int RC_W  = $clog2(TABLE_DEPTH + 1);
  localparam int IDX_W = $clog2(TABLE_DEPTH);
  localparam int E_W   = CNT_W + 32;

  logic [CNT_W-1:0] byte_count, byte_count_next;
  logic [RC_W-1:0]  run_count, run_count_next;
  logic [15:0]      last_row, last_col;
  out_word_t        res_next;
  logic             accept, wr_en, fin_now;
  logic [CNT_W:0]   sum;
  logic             need_entry;
  logic [IDX_W-1:0] rd_addr;
  logic [E_W-1:0]   rd_data;
  logic [CNT_W+16:0] bc_ext;
  logic [CNT_W+15:0] off_ext;
  srch_stat_t       sstat;

  assign accept = start && !busy;
  assign busy   = sstat.busy;

  spr_ram #(
    .WIDTH(E_W),
    .DEPTH(TABLE_DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (wr_en),
    .waddr(run_count[IDX_W-1:0]),
    .wdata({byte_count, cmd.src_row, cmd.src_col}),
    .raddr(rd_addr),
    .rdata(rd_data)
  );

  spr_search #(
    .TABLE_DEPTH(TABLE_DEPTH),
    .CNT_W      (CNT_W)
  ) u_search (
    .clk      (clk),
    .rst      (rst),
    .start    (accept && cmd.opcode == OP_LOOKUP && run_count != '0),
    .count    (run_count),
    .query    (cmd.query_offset),
    .rd_addr  (rd_addr),
    .rd_offset(rd_data[E_W-1:32]),
    .stat     (sstat)
  );

  always_comb begin
    byte_count_next = byte_count;
    run_count_next  = run_count;
    wr_en           = 1'b0;
    fin_now         = 1'b0;
    res_next        = '0;
    sum             = {1'b0, byte_count} + (CNT_W+1)'(cmd.extra_bytes);
    need_entry      = (run_count == '0) || (last_row != cmd.src_row) ||
                      (last_col != cmd.src_col);
    res_next.status = ST_OK;
    if (accept) begin
      fin_now = 1'b1;
      unique case (cmd.opcode)
        OP_TRACKED: begin
          if (byte_count >= CNT_W'(CODE_LIMIT)) begin
            res_next.status = ST_COUNTER_FULL;
          end else if (need_entry && run_count == RC_W'(TABLE_DEPTH)) begin
            res_next.status = ST_TABLE_FULL;
          end else begin
            if (need_entry) begin
              wr_en          = 1'b1;
              run_count_next = run_count + RC_W'(1);
            end
            byte_count_next = byte_count + CNT_W'(1);
          end
        end
        OP_UNTRACKED: begin
          if (sum > (CNT_W+1)'(CODE_LIMIT)) begin
            res_next.status = ST_COUNTER_FULL;
          end else begin
            byte_count_next = sum[CNT_W-1:0];
          end
        end
        OP_LOOKUP: begin
          if (run_count == '0) begin
            res_next.status = ST_EMPTY;
          end else begin
            fin_now = 1'b0;
          end
        end
        default: ;
      endcase
    end
    if (sstat.done) begin
      res_next.found_row = rd_data[31:16];
      res_next.found_col = rd_data[15:0];
      off_ext            = {16'b0, rd_data[E_W-1:32]};
      res_next.found_offset = off_ext[15:0];
    end else begin
      off_ext = '0;
    end
    bc_ext              = {17'b0, byte_count_next};
    res_next.byte_total = bc_ext[16:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count <= '0;
      run_count  <= '0;
      done       <= 1'b0;
    end else begin
      byte_count <= byte_count_next;
      run_count  <= run_count_next;
      done       <= fin_now || sstat.done;
    end
    if (wr_en) begin
      last_row <= cmd.src_row;
      last_col <= cmd.src_col;
    end
    if (fin_now || sstat.done) begin
      result <= res_next;
    end
  end

endmodule

@@ tb/testbench.sv @@
`timescale 1ns / 100ps
// Self-checking bench for source_position_run_table: random and directed command words,
// a shadow table that predicts each result word, and a monitor that checks them in order.
// Depends on spr_pkg and the RTL under hdl.
module testbench;
  import spr_pkg::*;

  localparam int RUN_SLOTS   = 256;
  localparam int BYTE_LIMIT  = 65536;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int RANDOM_CMDS = 1000;
  localparam int TAIL_CMDS   = 16;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      start = 1'b0;
  in_word_t  cmd = '0;
  logic      busy;
  logic      done;
  out_word_t result;

  source_position_run_table #(
    .TABLE_DEPTH(RUN_SLOTS),
    .CODE_LIMIT (BYTE_LIMIT)
  ) dut (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .cmd   (cmd),
    .done  (done),
    .result(result)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // shadow copy of the position table
  logic [15:0] shadow_offset [RUN_SLOTS];
  logic [15:0] shadow_row [RUN_SLOTS];
  logic [15:0] shadow_col [RUN_SLOTS];
  int          shadow_entries = 0;
  int          shadow_bytes = 0;

  // generator's view of the table, running ahead of the shadow copy by the words still queued
  logic [15:0] plan_row = '0;
  logic [15:0] plan_col = '0;
  int          plan_entries = 0;
  int          plan_bytes = 0;

  in_word_t  cmd_backlog [$];
  out_word_t answers_due [$];
  out_word_t want_word;

  int   gap_left = 0;
  int   calm_left = 0;
  logic steady = 1'b0;
  int   mismatches = 0;
  int   cycle_count = 0;
  int   n_accepted = 0;
  int   n_lookups = 0;
  int   n_table_full = 0;
  int   n_counter_full = 0;

  function automatic out_word_t table_response(in_word_t w);
    out_word_t r;
    logic      new_run;
    int        hit;
    r = '0;
    n_accepted++;
    case (op_t'(w.opcode))
      OP_TRACKED: begin
        if (shadow_bytes >= BYTE_LIMIT) begin
          r.status = ST_COUNTER_FULL;
        end else begin
          new_run = (shadow_entries == 0);
          if (!new_run)
            new_run = shadow_row[shadow_entries-1] != w.src_row ||
                      shadow_col[shadow_entries-1] != w.src_col;
          if (new_run && shadow_entries >= RUN_SLOTS) begin
            r.status = ST_TABLE_FULL;
          end else begin
            if (new_run) begin
              shadow_offset[shadow_entries] = shadow_bytes[15:0];
              shadow_row[shadow_entries] = w.src_row;
              shadow_col[shadow_entries] = w.src_col;
              shadow_entries++;
            end
            shadow_bytes++;
          end
        end
      end
      OP_UNTRACKED: begin
        if (shadow_bytes + int'(w.extra_bytes) > BYTE_LIMIT)
          r.status = ST_COUNTER_FULL;
        else
          shadow_bytes += w.extra_bytes;
      end
      OP_LOOKUP: begin
        n_lookups++;
        if (shadow_entries == 0) begin
          r.status = ST_EMPTY;
        end else begin
          // offsets rise strictly, so the last one not above the query wins
          hit = 0;
          for (int i = 0; i < shadow_entries; i++)
            if (shadow_offset[i] <= w.query_offset) hit = i;
          r.found_row = shadow_row[hit];
          r.found_col = shadow_col[hit];
          r.found_offset = shadow_offset[hit];
        end
      end
      default: ;
    endcase
    if (r.status == ST_TABLE_FULL) n_table_full++;
    if (r.status == ST_COUNTER_FULL) n_counter_full++;
    r.byte_total = shadow_bytes[16:0];
    return r;
  endfunction

  function automatic in_word_t make_cmd(op_t op, logic [15:0] row, logic [15:0] col,
                                        logic [2:0] n, logic [15:0] q);
    in_word_t w;
    w.opcode = op;
    w.src_row = row;
    w.src_col = col;
    w.extra_bytes = n;
    w.query_offset = q;
    return w;
  endfunction

  function automatic in_word_t random_command();
    in_word_t w;
    int       pick;
    w.opcode = OP_LOOKUP;
    w.src_row = 16'($urandom);
    w.src_col = 16'($urandom);
    w.extra_bytes = 3'($urandom);
    w.query_offset = 16'($urandom);
    pick = $urandom_range(0, 99);
    if (pick < 45) begin
      w.opcode = OP_TRACKED;
      case ($urandom_range(0, 9))
        0, 1, 2: begin
          w.src_row = plan_row;
          w.src_col = plan_col;
        end
        3: w.src_col = plan_col;
        4: w.src_row = plan_row;
        5: begin
          w.src_row = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
          w.src_col = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
        end
        default: ;
      endcase
      if (plan_entries == 0 || w.src_row != plan_row || w.src_col != plan_col) begin
        if (plan_entries < RUN_SLOTS) begin
          plan_entries++;
          plan_row = w.src_row;
          plan_col = w.src_col;
          plan_bytes++;
        end
      end else begin
        plan_bytes++;
      end
    end else if (pick < 70) begin
      w.opcode = OP_UNTRACKED;
      if ($urandom_range(0, 4) != 0) w.extra_bytes = 3'($urandom_range(1, 4));
      plan_bytes += w.extra_bytes;
    end else if (pick < 97) begin
      // aim most lookups at offsets that are in the table
      if ($urandom_range(0, 3) != 0)
        w.query_offset = 16'($urandom_range(0, plan_bytes + 1));
    end else begin
      w.opcode = OP_NONE;
    end
    return w;
  endfunction

  // wait until every word has gone in and every result has come back
  task automatic drain_all();
    do @(negedge clk);
    while (cmd_backlog.size() != 0 || start || answers_due.size() != 0);
  endtask

  // command driver
  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else if (!(start && busy)) begin
      if (start) begin
        answers_due.push_back(table_response(cmd));
        void'(cmd_backlog.pop_front());
      end
      if (calm_left > 0) calm_left--;
      else if ($urandom_range(0, 49) == 0) calm_left = $urandom_range(20, 60);
      if (gap_left > 0) begin
        gap_left--;
        start <= 1'b0;
      end else if (cmd_backlog.size() != 0 && !steady && calm_left == 0 &&
                   $urandom_range(0, 5) == 0) begin
        gap_left = $urandom_range(0, 5);
        start <= 1'b0;
      end else if (cmd_backlog.size() != 0) begin
        start <= 1'b1;
        cmd <= cmd_backlog[0];
      end else begin
        start <= 1'b0;
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (!rst && done) begin
      if (answers_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("result word with nothing outstanding: %p", result);
      end else begin
        want_word = answers_due.pop_front();
        if (result.found_row !== want_word.found_row ||
            result.found_col !== want_word.found_col ||
            result.found_offset !== want_word.found_offset ||
            result.byte_total !== want_word.byte_total ||
            result.status !== want_word.status) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("mismatch at cycle %0d: expected row %h col %h off %h bytes %h st %0d",
                     cycle_count, want_word.found_row, want_word.found_col,
                     want_word.found_offset, want_word.byte_total, want_word.status);
            $display("                      got row %h col %h off %h bytes %h st %0d",
                     result.found_row, result.found_col, result.found_offset,
                     result.byte_total, result.status);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timed out after %0d cycles", cycle_count);
      $display("source_position_run_table verification failed");
      $finish;
    end
  end

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // empty table, odd byte counts, unused opcode, then a few runs to search
    cmd_backlog.push_back(make_cmd(OP_LOOKUP, 16'h0000, 16'h0000, 3'd0, 16'h0000));
    cmd_backlog.push_back(make_cmd(OP_UNTRACKED, 16'hFFFF, 16'hFFFF, 3'd0, 16'hFFFF));
    cmd_backlog.push_back(make_cmd(OP_UNTRACKED, 16'h0000, 16'h0000, 3'd7, 16'h0000));
    cmd_backlog.push_back(make_cmd(OP_LOOKUP, 16'h0000, 16'h0000, 3'd0, 16'hFFFF));
    cmd_backlog.push_back(make_cmd(OP_NONE, 16'hFFFF, 16'hFFFF, 3'd7, 16'hFFFF));
    cmd_backlog.push_back(make_cmd(OP_TRACKED, 16'hFFFF, 16'hFFFF, 3'd7, 16'hFFFF));
    cmd_backlog.push_back(make_cmd(OP_TRACKED, 16'hFFFF, 16'hFFFF, 3'd0, 16'h0000));
    cmd_backlog.push_back(make_cmd(OP_TRACKED, 16'h0000, 16'h0000, 3'd0, 16'h0000));
    cmd_backlog.push_back(make_cmd(OP_TRACKED, 16'h0000, 16'h0001, 3'd0, 16'h0000));
    cmd_backlog.push_back(make_cmd(OP_TRACKED, 16'h0001, 16'h0001, 3'd0, 16'h0000));
    cmd_backlog.push_back(make_cmd(OP_UNTRACKED, 16'h0000, 16'h0000, 3'd4, 16'h0000));
    cmd_backlog.push_back(make_cmd(OP_UNTRACKED, 16'h0000, 16'h0000, 3'd1, 16'h0000));
    for (int q = 0; q < 14; q += 2)
      cmd_backlog.push_back(make_cmd(OP_LOOKUP, 16'h0000, 16'h0000, 3'd0, 16'(q)));
    cmd_backlog.push_back(make_cmd(OP_LOOKUP, 16'h0000, 16'h0000, 3'd0, 16'h000B));
    cmd_backlog.push_back(make_cmd(OP_LOOKUP, 16'h0000, 16'h0000, 3'd0, 16'hFFFF));
    drain_all();

    plan_entries = shadow_entries;
    plan_bytes = shadow_bytes;
    plan_row = shadow_row[shadow_entries-1];
    plan_col = shadow_col[shadow_entries-1];
    for (int i = 0; i < RANDOM_CMDS; i++) cmd_backlog.push_back(random_command());
    drain_all();

    // back-to-back words with no idling, then probe the last run and a full table
    steady = 1'b1;
    plan_entries = shadow_entries;
    plan_bytes = shadow_bytes;
    plan_row = shadow_row[shadow_entries-1];
    plan_col = shadow_col[shadow_entries-1];
    for (int i = 0; i < TAIL_CMDS; i++) cmd_backlog.push_back(random_command());
    cmd_backlog.push_back(make_cmd(OP_TRACKED, plan_row, plan_col, 3'd0, 16'h0000));
    cmd_backlog.push_back(make_cmd(OP_UNTRACKED, 16'h0000, 16'h0000, 3'd0, 16'h0000));
    cmd_backlog.push_back(make_cmd(OP_UNTRACKED, 16'h0000, 16'h0000, 3'd1, 16'h0000));
    cmd_backlog.push_back(make_cmd(OP_TRACKED, ~plan_row, 16'h0000, 3'd0, 16'h0000));
    cmd_backlog.push_back(make_cmd(OP_LOOKUP, 16'h0000, 16'h0000, 3'd0, 16'h0000));
    cmd_backlog.push_back(make_cmd(OP_LOOKUP, 16'h0000, 16'h0000, 3'd0, 16'hFFFF));
    cmd_backlog.push_back(make_cmd(OP_LOOKUP, 16'h0000, 16'h0000, 3'd0, 16'($urandom)));
    cmd_backlog.push_back(make_cmd(OP_NONE, 16'h0000, 16'h0000, 3'd0, 16'h0000));
    drain_all();
    repeat (20) @(posedge clk);

    mismatches += answers_due.size();
    $display("%0d command words checked, %0d of them lookups; %0d refused on a full table,",
             n_accepted, n_lookups, n_table_full);
    $display("%0d refused on a full counter; table ended with %0d runs over %0d bytes",
             n_counter_full, shadow_entries, shadow_bytes);
    if (mismatches == 0) begin
      $display("source_position_run_table verification clean");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("source_position_run_table verification failed");
    end
    $finish;
  end

endmodule

@@ source_position_run_table.f @@
hdl/spr_pkg.sv
hdl/spr_ram.sv
hdl/spr_search.sv
hdl/source_position_run_table.sv
tb/testbench.sv
